### src/iub_pkg.sv
package iub_pkg;

    localparam int ADDR_W     = 24;
    localparam int CH_W       = 8;
    localparam int IMG_W      = 13;
    localparam int POS_W      = 12;
    localparam int BPP_W      = 6;
    localparam int BYTES_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int DEF_MAX_SCALE = 8;
    localparam int DEF_DIM_BITS  = 12;

    // bytes per write saturate here
    localparam logic [BYTES_W-1:0] BYTES_MAX = BYTES_W'(4);

    // register reset values
    localparam logic [IMG_W-1:0] IMAGE_DIM_RST = IMG_W'(1);
    localparam logic [IMG_W-1:0] FB_WIDTH_RST  = IMG_W'(1);
    localparam logic [BPP_W-1:0] BPP_RST       = BPP_W'(32);

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_X        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Y        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FB_BPP       = 3'd7;

    typedef struct packed {
        logic load_pixel;
        logic scale_start;
        logic calc1;
        logic calc2;
        logic calc3;
        logic emit;
    } iub_cmd_t;

    typedef struct packed {
        logic image_start;
        logic scale_busy;
        logic scale_zero;
        logic block_last;
        logic out_free;
    } iub_status_t;

endpackage

### src/iub_ifs.sv
interface pixel_if;
    import iub_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] src_red;
    logic [CH_W-1:0] src_green;
    logic [CH_W-1:0] src_blue;
    logic [CH_W-1:0] src_alpha;

    modport source (output valid, output src_red, output src_green, output src_blue,
                    output src_alpha, input ready);
    modport sink   (input valid, input src_red, input src_green, input src_blue,
                    input src_alpha, output ready);
endinterface

interface write_if;
    import iub_pkg::*;

    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  pixel_address;
    logic [CH_W-1:0]    out_red;
    logic [CH_W-1:0]    out_green;
    logic [CH_W-1:0]    out_blue;
    logic [CH_W-1:0]    out_alpha;
    logic [BYTES_W-1:0] byte_count;
    logic               last_write;

    modport source (output valid, output pixel_address, output out_red, output out_green,
                    output out_blue, output out_alpha, output byte_count,
                    output last_write, input ready);
    modport sink   (input valid, input pixel_address, input out_red, input out_green,
                    input out_blue, input out_alpha, input byte_count,
                    input last_write, output ready);
endinterface

### src/integer_upscale_blit_top.sv
// Nearest-neighbor integer upscaler. Source RGBA pixels come in raster order on
// pixel_in; each one becomes an s-by-s block of framebuffer writes on write_out,
// row by row, left to right, with last_write set on the block's final beat.
// s = min(box_width / image_width, box_height / image_height), capped at
// MAX_SCALE, latched when a pixel arrives with both raster counters at zero
// (start of image); a zero image dimension gives s = 0, and s = 0 emits no
// beats while the counters still advance. Addresses are
// box_y*fb_width + box_x + (row*s + i)*fb_width + col*s + j, modulo 2^24.
// The user must write configuration through cfg_write/cfg_index/cfg_data only
// while the block is idle; the block does not enforce this. It takes one pixel
// at a time: a three-step address setup, then one write beat per cycle while
// the output register is free; s = 0 returns to idle after the first step. A
// pixel that starts an image adds the scale search, which steps one multiple of
// the image size per cycle. The last beat of a block may sit in the output
// register while the next pixel is accepted; a stalled sink holds the block.
module integer_upscale_blit_top
    import iub_pkg::*;
#(
    parameter int MAX_SCALE = DEF_MAX_SCALE,
    parameter int DIM_BITS  = DEF_DIM_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    pixel_if.sink                 pixel_in,
    write_if.source               write_out
);

    iub_cmd_t    cmd;
    iub_status_t status;

    // sequencing: accept, scale search, address setup, write beats
    iub_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel_in.valid),
        .in_ready (pixel_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // registers, counters, address arithmetic and output register
    iub_datapath #(
        .MAX_SCALE (MAX_SCALE),
        .DIM_BITS  (DIM_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src_red   (pixel_in.src_red),
        .src_green (pixel_in.src_green),
        .src_blue  (pixel_in.src_blue),
        .src_alpha (pixel_in.src_alpha),
        .cmd       (cmd),
        .status    (status),
        .write_out (write_out)
    );

endmodule

### src/iub_scale.sv
module iub_scale
    import iub_pkg::*;
#(
    parameter int MAX_SCALE = DEF_MAX_SCALE,
    localparam int SW = $clog2(MAX_SCALE + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [IMG_W-1:0] image_width,
    input  logic [IMG_W-1:0] image_height,
    input  logic [IMG_W-1:0] box_width,
    input  logic [IMG_W-1:0] box_height,
    output logic             busy,
    output logic [SW-1:0]    scale
);

    // acc holds (k+1) * dim, at most (MAX_SCALE+1) * dim
    localparam int AW = IMG_W + SW;

    logic [SW-1:0] k_reg;
    logic [AW-1:0] acc_w_reg;
    logic [AW-1:0] acc_h_reg;
    logic          busy_reg;
    logic [SW-1:0] scale_reg;
    logic          fits;

    // one more multiple of the image still fits in the box and MAX_SCALE is not reached
    always_comb
    begin
        fits = (k_reg < SW'(MAX_SCALE)) &&
               (acc_w_reg <= AW'(box_width)) &&
               (acc_h_reg <= AW'(box_height));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            acc_w_reg <= '0;
            acc_h_reg <= '0;
            busy_reg  <= 1'b0;
            scale_reg <= '0;
        end
        else if (start)
        begin
            if (image_width == '0 || image_height == '0)
            begin
                scale_reg <= '0;
                busy_reg  <= 1'b0;
            end
            else
            begin
                k_reg     <= '0;
                acc_w_reg <= AW'(image_width);
                acc_h_reg <= AW'(image_height);
                busy_reg  <= 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                k_reg     <= k_reg + SW'(1);
                acc_w_reg <= acc_w_reg + AW'(image_width);
                acc_h_reg <= acc_h_reg + AW'(image_height);
            end
            else
            begin
                scale_reg <= k_reg;
                busy_reg  <= 1'b0;
            end
        end
    end

    assign busy  = busy_reg;
    assign scale = scale_reg;

endmodule

### src/iub_datapath.sv
module iub_datapath
    import iub_pkg::*;
#(
    parameter int MAX_SCALE = DEF_MAX_SCALE,
    parameter int DIM_BITS  = DEF_DIM_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [CH_W-1:0]       src_red,
    input  logic [CH_W-1:0]       src_green,
    input  logic [CH_W-1:0]       src_blue,
    input  logic [CH_W-1:0]       src_alpha,
    input  iub_cmd_t              cmd,
    output iub_status_t           status,
    write_if.source               write_out
);

    localparam int SW  = $clog2(MAX_SCALE + 1);
    localparam int RSW = DIM_BITS + SW;
    localparam int CW  = ((DIM_BITS > IMG_W) ? DIM_BITS : IMG_W) + 1;

    // configuration registers
    logic [IMG_W-1:0] image_width_reg;
    logic [IMG_W-1:0] image_height_reg;
    logic [POS_W-1:0] box_x_reg;
    logic [POS_W-1:0] box_y_reg;
    logic [IMG_W-1:0] box_width_reg;
    logic [IMG_W-1:0] box_height_reg;
    logic [IMG_W-1:0] fb_width_reg;
    logic [BPP_W-1:0] fb_bpp_reg;

    logic [CH_W-1:0] red_reg, green_reg, blue_reg, alpha_reg;

    logic [DIM_BITS-1:0] col_reg, col_next;
    logic [DIM_BITS-1:0] row_reg, row_next;

    logic [ADDR_W-1:0] base_prod_reg;
    logic [RSW-1:0]    rs_reg;
    logic [RSW-1:0]    cs_reg;
    logic [ADDR_W-1:0] rowoff_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] line_reg;
    logic [SW-1:0]     i_reg;
    logic [SW-1:0]     j_reg;

    logic               out_valid_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [CH_W-1:0]    out_red_reg, out_green_reg, out_blue_reg, out_alpha_reg;
    logic [BYTES_W-1:0] out_bytes_reg;
    logic               out_last_reg;

    logic [SW-1:0]      scale;
    logic               scale_busy;
    logic [SW-1:0]      scale_m1;
    logic               row_end;
    logic               block_end;
    logic [BYTES_W-1:0] bytes;
    logic [CW-1:0]      col_inc;
    logic [CW-1:0]      row_inc;
    logic [ADDR_W-1:0]  line_step;

    iub_scale #(
        .MAX_SCALE (MAX_SCALE)
    ) u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (cmd.scale_start),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .box_width    (box_width_reg),
        .box_height   (box_height_reg),
        .busy         (scale_busy),
        .scale        (scale)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_DIM_RST;
            image_height_reg <= IMAGE_DIM_RST;
            box_x_reg        <= '0;
            box_y_reg        <= '0;
            box_width_reg    <= '0;
            box_height_reg   <= '0;
            fb_width_reg     <= FB_WIDTH_RST;
            fb_bpp_reg       <= BPP_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                REG_BOX_X:        box_x_reg        <= cfg_data[POS_W-1:0];
                REG_BOX_Y:        box_y_reg        <= cfg_data[POS_W-1:0];
                REG_BOX_WIDTH:    box_width_reg    <= cfg_data;
                REG_BOX_HEIGHT:   box_height_reg   <= cfg_data;
                REG_FB_WIDTH:     fb_width_reg     <= cfg_data;
                REG_FB_BPP:       fb_bpp_reg       <= cfg_data[BPP_W-1:0];
                default: ;
            endcase
        end
    end

    // raster counters: wrap on image size or on counter overflow
    always_comb
    begin
        col_inc  = CW'(col_reg) + CW'(1);
        row_inc  = CW'(row_reg) + CW'(1);
        col_next = col_inc[DIM_BITS-1:0];
        row_next = row_reg;
        if (col_inc >= CW'(image_width_reg) || col_inc[DIM_BITS-1:0] == '0)
        begin
            col_next = '0;
            if (row_inc >= CW'(image_height_reg) || row_inc[DIM_BITS-1:0] == '0)
                row_next = '0;
            else
                row_next = row_inc[DIM_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.calc1)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_comb
    begin
        scale_m1  = scale - SW'(1);
        row_end   = (j_reg == scale_m1);
        block_end = row_end && (i_reg == scale_m1);
        bytes     = (fb_bpp_reg[5:3] > BYTES_MAX) ? BYTES_MAX : fb_bpp_reg[5:3];
        line_step = line_reg + ADDR_W'(fb_width_reg);
    end

    // pixel latch, address setup (multiplies in the first two steps) and output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_pixel)
        begin
            red_reg   <= src_red;
            green_reg <= src_green;
            blue_reg  <= src_blue;
            alpha_reg <= src_alpha;
        end
        if (cmd.calc1)
        begin
            base_prod_reg <= ADDR_W'(box_y_reg) * ADDR_W'(fb_width_reg);
            rs_reg        <= RSW'(row_reg) * RSW'(scale);
            cs_reg        <= RSW'(col_reg) * RSW'(scale);
        end
        if (cmd.calc2)
        begin
            rowoff_reg <= ADDR_W'(rs_reg) * ADDR_W'(fb_width_reg);
            base_reg   <= base_prod_reg + ADDR_W'(box_x_reg);
        end
        if (cmd.calc3)
        begin
            addr_reg <= base_reg + rowoff_reg + ADDR_W'(cs_reg);
            line_reg <= base_reg + rowoff_reg + ADDR_W'(cs_reg);
        end
        else if (cmd.emit)
        begin
            if (row_end)
            begin
                line_reg <= line_step;
                addr_reg <= line_step;
            end
            else
                addr_reg <= addr_reg + ADDR_W'(1);
        end
        if (cmd.emit)
        begin
            out_addr_reg  <= addr_reg;
            out_red_reg   <= red_reg;
            out_green_reg <= green_reg;
            out_blue_reg  <= blue_reg;
            out_alpha_reg <= alpha_reg;
            out_bytes_reg <= bytes;
            out_last_reg  <= block_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.calc3)
            begin
                i_reg <= '0;
                j_reg <= '0;
            end
            else if (cmd.emit)
            begin
                if (row_end)
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + SW'(1);
                end
                else
                    j_reg <= j_reg + SW'(1);
            end

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (write_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        status.image_start = (col_reg == '0) && (row_reg == '0);
        status.scale_busy  = scale_busy;
        status.scale_zero  = (scale == '0);
        status.block_last  = block_end;
        status.out_free    = !out_valid_reg || write_out.ready;
    end

    assign write_out.valid         = out_valid_reg;
    assign write_out.pixel_address = out_addr_reg;
    assign write_out.out_red       = out_red_reg;
    assign write_out.out_green     = out_green_reg;
    assign write_out.out_blue      = out_blue_reg;
    assign write_out.out_alpha     = out_alpha_reg;
    assign write_out.byte_count    = out_bytes_reg;
    assign write_out.last_write    = out_last_reg;

endmodule

### src/iub_ctrl.sv
module iub_ctrl
    import iub_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  iub_status_t status,
    output iub_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCALE = 6'b000010,
        ST_CALC1 = 6'b000100,
        ST_CALC2 = 6'b001000,
        ST_CALC3 = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_pixel = 1'b1;
                    if (status.image_start)
                    begin
                        cmd.scale_start = 1'b1;
                        state_next      = ST_SCALE;
                    end
                    else
                        state_next = ST_CALC1;
                end
            end
            ST_SCALE:
            begin
                if (!status.scale_busy)
                    state_next = ST_CALC1;
            end
            ST_CALC1:
            begin
                cmd.calc1  = 1'b1;
                state_next = status.scale_zero ? ST_IDLE : ST_CALC2;
            end
            ST_CALC2:
            begin
                cmd.calc2  = 1'b1;
                state_next = ST_CALC3;
            end
            ST_CALC3:
            begin
                cmd.calc3  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.block_last)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
